/* hw/rtl/assert_macros.svh */
// Assertion helpers used by the top-level RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define SH_ASSERT_IMPLIES(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("sh_p2c: property violated");

`define SH_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("sh_p2c: forbidden condition seen");

`else

`define SH_ASSERT_IMPLIES(lbl, clk, rstn, prop)

`define SH_ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

/* hw/rtl/sh_p2c_pkg.sv */
package sh_p2c_pkg;

    localparam int unsigned MAX_SAMPLES  = 4096;
    localparam int unsigned GATE_MM      = 1581;

    localparam int unsigned IDX_W        = 12;
    localparam int unsigned RANGE_W      = 16;
    localparam int unsigned PT_W         = 12;
    localparam int unsigned XY_W         = 29;
    localparam int unsigned Z_W          = 20;
    localparam int unsigned CORDIC_STEPS = 16;

    localparam int unsigned IN_TDATA_W   = 32;
    localparam int unsigned OUT_TDATA_W  = 40;

    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned CFG_DATA_W   = 17;

    localparam int unsigned PI_Q14       = 51472;
    localparam int unsigned TWO_PI_Q14   = 102944;
    localparam int unsigned HALF_PI_Q14  = 25736;
    localparam int unsigned GAIN_Q30     = 652032874;
    localparam int unsigned RECIP_Q35    = 333771;
    localparam int unsigned RECIP_SHIFT  = 35;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_RANGE  = 3'd0,
        CFG_MAX_RANGE  = 3'd1,
        CFG_START      = 3'd2,
        CFG_STEP       = 3'd3,
        CFG_SCAN_LEN   = 3'd4,
        CFG_LEFT_SIDE  = 3'd5
    } t_cfg_index;

    typedef logic signed [XY_W-1:0] t_xy;
    typedef logic signed [Z_W-1:0]  t_z;

    typedef struct packed {
        logic             vld;
        logic             neg;
        logic [IDX_W-1:0] idx;
        t_xy              x;
        t_xy              y;
        t_z               z;
    } t_cordic_word;

    typedef struct packed {
        logic out_vld;
        logic skid_vld;
    } t_post_status;

    function automatic t_z atan_q16(input int unsigned step);
        t_z v;
        unique case (step)
            0:       v = 20'sd51472;
            1:       v = 20'sd30386;
            2:       v = 20'sd16055;
            3:       v = 20'sd8150;
            4:       v = 20'sd4091;
            5:       v = 20'sd2047;
            6:       v = 20'sd1024;
            7:       v = 20'sd512;
            8:       v = 20'sd256;
            9:       v = 20'sd128;
            10:      v = 20'sd64;
            11:      v = 20'sd32;
            12:      v = 20'sd16;
            13:      v = 20'sd8;
            14:      v = 20'sd4;
            15:      v = 20'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/scan_half_polar_to_cartesian.sv */
// Half-scan polar to Cartesian converter for laser range samples.
// Input words (s_axis) carry a scan index and a range in millimetres. A word
// is kept when its index lies in the selected half of the scan and its range
// lies strictly between the lower limit and the smaller of the upper limit
// and the 1581 mm gate; a kept word leaves m_axis as one point (x, y, index),
// dropped words leave nothing. Order is preserved.
// Configuration is written through i_cfg_wr_en / i_cfg_index / i_cfg_data,
// by the user only while the block is idle; the block does not enforce it.
// Registers: min/max range, start angle, angle step, scan length, left side.
// Throughput: one word per cycle while s_axis_tready is high. Each word
// passes the angle-reduction registers, 16 CORDIC cells and 1 output
// register. Dropped words take the same slots as bubbles.
// Reset clears all valid flags and loads the register reset values; no
// clearing pass is needed.
// When the receiver stalls, the output register holds its word and one more
// result lands in a skid register; s_axis_tready then drops until the skid
// word moves to the output. The whole pipeline advances on one enable.
`include "assert_macros.svh"

module scan_half_polar_to_cartesian (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wr_en,
    input  logic [sh_p2c_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sh_p2c_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [11:0] sample_index, [27:12] range_mm, [31:28] zero
    input  logic [sh_p2c_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // [11:0] point_x_mm, [23:12] point_y_mm, [35:24] point_index, [39:36] zero
    output logic [sh_p2c_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    localparam int unsigned STEPS = sh_p2c_pkg::CORDIC_STEPS;

    sh_p2c_pkg::t_cordic_word             w_chain [0:STEPS];
    sh_p2c_pkg::t_post_status             w_status;
    logic                                 w_en;
    logic [sh_p2c_pkg::PT_W-1:0]          w_x;
    logic [sh_p2c_pkg::PT_W-1:0]          w_y;
    logic [sh_p2c_pkg::IDX_W-1:0]         w_idx;

    assign w_en          = !w_status.skid_vld;
    assign s_axis_tready = w_en;

    sh_p2c_prep u_prep (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_tvalid       (s_axis_tvalid),
        .i_sample_index (s_axis_tdata[11:0]),
        .i_range_mm     (s_axis_tdata[27:12]),
        .o_word         (w_chain[0])
    );

    for (genvar g = 0; g < STEPS; g++) begin : g_cell
        sh_p2c_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_word  (w_chain[g]),
            .o_word  (w_chain[g+1])
        );
    end

    sh_p2c_post u_post (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_word        (w_chain[STEPS]),
        .i_tready      (m_axis_tready),
        .o_tvalid      (m_axis_tvalid),
        .o_point_x_mm  (w_x),
        .o_point_y_mm  (w_y),
        .o_point_index (w_idx),
        .o_status      (w_status)
    );

    assign m_axis_tdata = {4'b0000, w_idx, w_y, w_x};

    `SH_ASSERT_NEVER(a_stall_without_word, i_clk, i_rst_n, !s_axis_tready && !m_axis_tvalid)
    `SH_ASSERT_IMPLIES(a_skid_holds, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready && !s_axis_tready |=> !s_axis_tready)
    `SH_ASSERT_IMPLIES(a_skid_cause, i_clk, i_rst_n, $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))

endmodule

/* hw/rtl/sh_p2c_prep.sv */
module sh_p2c_prep (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_cfg_wr_en,
    input  logic [sh_p2c_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sh_p2c_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                 i_tvalid,
    input  logic [sh_p2c_pkg::IDX_W-1:0]         i_sample_index,
    input  logic [sh_p2c_pkg::RANGE_W-1:0]       i_range_mm,
    output sh_p2c_pkg::t_cordic_word             o_word
);

    localparam int unsigned Q_W     = 9;
    localparam int unsigned V_W     = 26;
    localparam int unsigned REM_W   = 18;
    localparam int unsigned PROD_W  = 25;
    localparam int unsigned X0_W    = 27;
    localparam int unsigned IDX_W_L = sh_p2c_pkg::IDX_W;

    logic [15:0] r_min_range;
    logic [15:0] r_max_range;
    logic [16:0] r_start;
    logic [12:0] r_step;
    logic [12:0] r_scan_len;
    logic        r_left_side;

    logic [12:0] w_len;
    logic [11:0] w_half;
    logic [15:0] w_upper;
    logic        w_side_ok;
    logic        w_range_ok;
    logic [40:0] w_gain;

    logic              r_p1_vld;
    logic [IDX_W_L-1:0] r_p1_idx;
    logic [PROD_W-1:0] r_p1_prod;
    logic [X0_W-1:0]   r_p1_x0;

    logic              r_p2_vld;
    logic [11:0]       r_p2_idx;
    logic [V_W-1:0]    r_p2_v;
    logic [X0_W-1:0]   r_p2_x0;
    logic [26:0]       w_v;

    logic              r_p3_vld;
    logic [11:0]       r_p3_idx;
    logic [V_W-1:0]    r_p3_v;
    logic [Q_W-1:0]    r_p3_q;
    logic [X0_W-1:0]   r_p3_x0;
    logic [44:0]       w_qprod;

    logic              r_p4_vld;
    logic [11:0]       r_p4_idx;
    logic [REM_W-1:0]  r_p4_rem;
    logic [X0_W-1:0]   r_p4_x0;
    logic [V_W-1:0]    w_qd;

    logic [REM_W-1:0]  w_a1;
    logic signed [17:0] w_a;
    logic signed [17:0] w_a2;
    logic              w_neg;

    sh_p2c_pkg::t_cordic_word r_q;
    sh_p2c_pkg::t_cordic_word n_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_range <= '0;
            r_max_range <= 16'hFFFF;
            r_start     <= '0;
            r_step      <= '0;
            r_scan_len  <= 13'(sh_p2c_pkg::MAX_SAMPLES);
            r_left_side <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (sh_p2c_pkg::t_cfg_index'(i_cfg_index))
                sh_p2c_pkg::CFG_MIN_RANGE: r_min_range <= i_cfg_data[15:0];
                sh_p2c_pkg::CFG_MAX_RANGE: r_max_range <= i_cfg_data[15:0];
                sh_p2c_pkg::CFG_START:     r_start     <= i_cfg_data[16:0];
                sh_p2c_pkg::CFG_STEP:      r_step      <= i_cfg_data[12:0];
                sh_p2c_pkg::CFG_SCAN_LEN:  r_scan_len  <= i_cfg_data[12:0];
                sh_p2c_pkg::CFG_LEFT_SIDE: r_left_side <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_len   = (r_scan_len > 13'(sh_p2c_pkg::MAX_SAMPLES)) ?
                  13'(sh_p2c_pkg::MAX_SAMPLES) : r_scan_len;
        w_half  = w_len[12:1];
        w_upper = (r_max_range > 16'(sh_p2c_pkg::GATE_MM)) ?
                  16'(sh_p2c_pkg::GATE_MM) : r_max_range;
        if (r_left_side) begin
            w_side_ok = (i_sample_index > w_half) && ({1'b0, i_sample_index} < w_len);
        end else begin
            w_side_ok = i_sample_index < w_half;
        end
        w_range_ok = (r_min_range < i_range_mm) && (i_range_mm < w_upper);
        w_gain = 41'(i_range_mm[10:0]) * 41'(sh_p2c_pkg::GAIN_Q30) + 41'(8192);
    end

    always_comb begin
        w_v     = {{10{r_start[16]}}, r_start} + {2'b00, r_p1_prod}
                + 27'(sh_p2c_pkg::PI_Q14 + sh_p2c_pkg::TWO_PI_Q14);
        w_qprod = 45'(r_p2_v) * 45'(sh_p2c_pkg::RECIP_Q35);
        w_qd    = V_W'(r_p3_q) * V_W'(sh_p2c_pkg::TWO_PI_Q14);
    end

    always_comb begin
        w_a1 = (r_p4_rem >= REM_W'(sh_p2c_pkg::TWO_PI_Q14)) ?
               r_p4_rem - REM_W'(sh_p2c_pkg::TWO_PI_Q14) : r_p4_rem;
        w_a  = $signed(w_a1) - 18'sd51472;
        if (w_a > 18'sd25736) begin
            w_a2  = w_a - 18'sd51472;
            w_neg = 1'b1;
        end else if (w_a < -18'sd25736) begin
            w_a2  = w_a + 18'sd51472;
            w_neg = 1'b1;
        end else begin
            w_a2  = w_a;
            w_neg = 1'b0;
        end
        n_q.vld = r_p4_vld;
        n_q.neg = w_neg;
        n_q.idx = r_p4_idx;
        n_q.x   = sh_p2c_pkg::t_xy'({2'b00, r_p4_x0});
        n_q.y   = '0;
        n_q.z   = sh_p2c_pkg::t_z'({w_a2, 2'b00});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
            r_p4_vld <= 1'b0;
            r_q.vld  <= 1'b0;
        end else if (i_en) begin
            r_p1_vld <= i_tvalid && w_side_ok && w_range_ok;
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;
            r_p4_vld <= r_p3_vld;
            r_q      <= n_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1_idx  <= i_sample_index;
            r_p1_prod <= PROD_W'(i_sample_index) * PROD_W'(r_step);
            r_p1_x0   <= w_gain[40:14];

            r_p2_idx  <= r_p1_idx;
            r_p2_v    <= w_v[V_W-1:0];
            r_p2_x0   <= r_p1_x0;

            r_p3_idx  <= r_p2_idx;
            r_p3_v    <= r_p2_v;
            r_p3_q    <= w_qprod[sh_p2c_pkg::RECIP_SHIFT+Q_W-1:sh_p2c_pkg::RECIP_SHIFT];
            r_p3_x0   <= r_p2_x0;

            r_p4_idx  <= r_p3_idx;
            r_p4_rem  <= REM_W'(r_p3_v - w_qd);
            r_p4_x0   <= r_p3_x0;
        end
    end

    assign o_word = r_q;

endmodule

/* hw/rtl/sh_p2c_cell.sv */
module sh_p2c_cell #(
    parameter int unsigned STAGE = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  sh_p2c_pkg::t_cordic_word i_word,
    output sh_p2c_pkg::t_cordic_word o_word
);

    sh_p2c_pkg::t_xy          w_dx;
    sh_p2c_pkg::t_xy          w_dy;
    sh_p2c_pkg::t_z           w_t;
    sh_p2c_pkg::t_cordic_word r_q;
    sh_p2c_pkg::t_cordic_word n_q;

    always_comb begin
        w_dx = i_word.y >>> STAGE;
        w_dy = i_word.x >>> STAGE;
        w_t  = sh_p2c_pkg::atan_q16(STAGE);
        n_q  = i_word;
        if (i_word.z >= 0) begin
            n_q.x = i_word.x - w_dx;
            n_q.y = i_word.y + w_dy;
            n_q.z = i_word.z - w_t;
        end else begin
            n_q.x = i_word.x + w_dx;
            n_q.y = i_word.y - w_dy;
            n_q.z = i_word.z + w_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.vld <= 1'b0;
        end else if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_word = r_q;

endmodule

/* hw/rtl/sh_p2c_post.sv */
module sh_p2c_post (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sh_p2c_pkg::t_cordic_word        i_word,
    input  logic                            i_tready,
    output logic                            o_tvalid,
    output logic [sh_p2c_pkg::PT_W-1:0]     o_point_x_mm,
    output logic [sh_p2c_pkg::PT_W-1:0]     o_point_y_mm,
    output logic [sh_p2c_pkg::IDX_W-1:0]    o_point_index,
    output sh_p2c_pkg::t_post_status        o_status
);

    localparam int unsigned PT_W  = sh_p2c_pkg::PT_W;
    localparam int unsigned IDX_W = sh_p2c_pkg::IDX_W;

    function automatic logic [PT_W-1:0] round_sat(input sh_p2c_pkg::t_xy v,
                                                  input logic neg);
        sh_p2c_pkg::t_xy    sum;
        sh_p2c_pkg::t_xy    sh;
        logic signed [13:0] m;
        logic [PT_W-1:0]    res;
        sum = v + sh_p2c_pkg::t_xy'(32768);
        sh  = sum >>> 16;
        m   = neg ? -$signed(sh[13:0]) : $signed(sh[13:0]);
        if (m > 14'sd2047) begin
            res = 12'h7FF;
        end else if (m < -14'sd2048) begin
            res = 12'h800;
        end else begin
            res = m[PT_W-1:0];
        end
        return res;
    endfunction

    logic [PT_W-1:0]  w_x;
    logic [PT_W-1:0]  w_y;

    logic             r_out_vld;
    logic [PT_W-1:0]  r_out_x;
    logic [PT_W-1:0]  r_out_y;
    logic [IDX_W-1:0] r_out_idx;
    logic             r_skid_vld;
    logic [PT_W-1:0]  r_skid_x;
    logic [PT_W-1:0]  r_skid_y;
    logic [IDX_W-1:0] r_skid_idx;

    always_comb begin
        w_x = round_sat(i_word.x, i_word.neg);
        w_y = round_sat(i_word.y, i_word.neg);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (i_tready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (i_word.vld) begin
            if (!r_out_vld || i_tready) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (i_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (i_tready) begin
                r_out_x   <= r_skid_x;
                r_out_y   <= r_skid_y;
                r_out_idx <= r_skid_idx;
            end
        end else if (i_word.vld) begin
            if (!r_out_vld || i_tready) begin
                r_out_x   <= w_x;
                r_out_y   <= w_y;
                r_out_idx <= i_word.idx;
            end else begin
                r_skid_x   <= w_x;
                r_skid_y   <= w_y;
                r_skid_idx <= i_word.idx;
            end
        end
    end

    assign o_tvalid      = r_out_vld;
    assign o_point_x_mm  = r_out_x;
    assign o_point_y_mm  = r_out_y;
    assign o_point_index = r_out_idx;
    assign o_status      = '{out_vld: r_out_vld, skid_vld: r_skid_vld};

endmodule

/* bench/scan_half_polar_to_cartesian_test.sv */
module scan_half_polar_to_cartesian_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int SETTLE_TICKS = 30;
    localparam int QUIET_LIMIT  = 3000;
    localparam int HOLD_TICKS   = 400;
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 200;
    localparam int PLAN_ROWS    = 48;

    localparam longint HALF_TURN    = 51472;
    localparam longint FULL_TURN    = 102944;
    localparam longint QUARTER_TURN = 25736;
    localparam longint RANGE_GAIN   = 652032874;

    typedef struct packed {
        logic [11:0]        idx;
        logic signed [11:0] y;
        logic signed [11:0] x;
    } t_cart_point;

    typedef enum logic [1:0] {
        ROW_WRITE   = 2'd0,
        ROW_KEPT    = 2'd1,
        ROW_DROPPED = 2'd2
    } t_row_kind;

    typedef struct packed {
        t_row_kind               kind;
        sh_p2c_pkg::t_cfg_index  reg_sel;
        logic [16:0]             reg_val;
        logic [11:0]             idx;
        logic [15:0]             rng;
    } t_plan_row;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_wr_en = 1'b0;
    logic [sh_p2c_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [sh_p2c_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    // [11:0] sample_index, [27:12] range_mm, [31:28] zero
    logic [sh_p2c_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    // [11:0] point_x_mm, [23:12] point_y_mm, [35:24] point_index, [39:36] zero
    logic [sh_p2c_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    logic [15:0]        lo_gate_mm;
    logic [15:0]        hi_limit_mm;
    logic signed [16:0] angle_origin;
    logic [12:0]        angle_pitch;
    logic [12:0]        samples_per_scan;
    logic               use_left;

    longint      arctan_q16 [0:15] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                       256, 128, 64, 32, 16, 8, 4, 2};
    t_cart_point pending_points [$];
    bit          steady = 1'b0;
    bit          hold_req = 1'b0;
    int          fault_count = 0;
    int          points_checked = 0;
    int          samples_sent = 0;
    int          settings_used = 0;
    int          quiet_cycles = 0;

    t_plan_row plan [PLAN_ROWS] = '{
        '{ROW_KEPT,    sh_p2c_pkg::CFG_MIN_RANGE, 17'd0,     12'd0,    16'd1580},
        '{ROW_DROPPED, sh_p2c_pkg::CFG_MIN_RANGE, 17'd0,     12'd0,    16'd1581},
        '{ROW_DROPPED, sh_p2c_pkg::CFG_MIN_RANGE, 17'd0,     12'd0,    16'd0},
        '{ROW_DROPPED, sh_p2c_pkg::CFG_MIN_RANGE, 17'd0,     12'd5,    16'd65535},
        '{ROW_KEPT,    sh_p2c_pkg::CFG_MIN_RANGE, 17'd0,     12'd2047, 16'd1},
        '{ROW_DROPPED, sh_p2c_pkg::CFG_MIN_RANGE, 17'd0,     12'd2048, 16'd100},
        '{ROW_WRITE,   sh_p2c_pkg::CFG_START,     17'h136F0, 12'd0,    16'd0},
        '{ROW_WRITE,   sh_p2c_pkg::CFG_STEP,      17'd4096,  12'd0,    16'd0},
        '{ROW_WRITE,   sh_p2c_pkg::CFG_LEFT_SIDE, 17'd1,     12'd0,    16'd0},
        '{ROW_DROPPED, sh_p2c_pkg::CFG_MIN_RANGE, 17'd0,     12'd2048, 16'd500},
        '{ROW_KEPT,    sh_p2c_pkg::CFG_MIN_RANGE, 17'd0,     12'd2049, 16'd1580},
        '{ROW_KEPT,    sh_p2c_pkg::CFG_MIN_RANGE, 17'd0,     12'd4095, 16'd1580},
        '{ROW_WRITE,   sh_p2c_pkg::CFG_SCAN_LEN,  17'd8191,  12'd0,    16'd0},
        '{ROW_WRITE,   sh_p2c_pkg::CFG_START,     17'h0C910, 12'd0,    16'd0},
        '{ROW_WRITE,   sh_p2c_pkg::CFG_STEP,      17'd8191,  12'd0,    16'd0},
        '{ROW_KEPT,    sh_p2c_pkg::CFG_MIN_RANGE, 17'd0,     12'd4095, 16'd1000},
        '{ROW_WRITE,   sh_p2c_pkg::CFG_LEFT_SIDE, 17'd0,     12'd0,    16'd0},
        '{ROW_WRITE,   sh_p2c_pkg::CFG_STEP,      17'd0,     12'd0,    16'd0},
        '{ROW_WRITE,   sh_p2c_pkg::CFG_START,     17'h06488, 12'd0,    16'd0},
        '{ROW_KEPT,    sh_p2c_pkg::CFG_MIN_RANGE, 17'd0,     12'd0,    16'd1200},
        '{ROW_WRITE,   sh_p2c_pkg::CFG_START,     17'h06489, 12'd0,    16'd0},
        '{ROW_KEPT,    sh_p2c_pkg::CFG_MIN_RANGE, 17'd0,     12'd1,    16'd1200},
        '{ROW_WRITE,   sh_p2c_pkg::CFG_START,     17'h19B77, 12'd0,    16'd0},
        '{ROW_KEPT,    sh_p2c_pkg::CFG_MIN_RANGE, 17'd0,     12'd2,    16'd1200},
        '{ROW_WRITE,   sh_p2c_pkg::CFG_START,     17'h10000, 12'd0,    16'd0},
        '{ROW_KEPT,    sh_p2c_pkg::CFG_MIN_RANGE, 17'd0,     12'd3,    16'd777},
        '{ROW_WRITE,   sh_p2c_pkg::CFG_SCAN_LEN,  17'd1,     12'd0,    16'd0},
        '{ROW_DROPPED, sh_p2c_pkg::CFG_MIN_RANGE, 17'd0,     12'd0,    16'd100},
        '{ROW_WRITE,   sh_p2c_pkg::CFG_LEFT_SIDE, 17'd1,     12'd0,    16'd0},
        '{ROW_DROPPED, sh_p2c_pkg::CFG_MIN_RANGE, 17'd0,     12'd0,    16'd100},
        '{ROW_DROPPED, sh_p2c_pkg::CFG_MIN_RANGE, 17'd0,     12'd1,    16'd100},
        '{ROW_WRITE,   sh_p2c_pkg::CFG_SCAN_LEN,  17'd0,     12'd0,    16'd0},
        '{ROW_DROPPED, sh_p2c_pkg::CFG_MIN_RANGE, 17'd0,     12'd0,    16'd100},
        '{ROW_WRITE,   sh_p2c_pkg::CFG_SCAN_LEN,  17'd2,     12'd0,    16'd0},
        '{ROW_WRITE,   sh_p2c_pkg::CFG_LEFT_SIDE, 17'd0,     12'd0,    16'd0},
        '{ROW_KEPT,    sh_p2c_pkg::CFG_MIN_RANGE, 17'd0,     12'd0,    16'd1000},
        '{ROW_WRITE,   sh_p2c_pkg::CFG_LEFT_SIDE, 17'd1,     12'd0,    16'd0},
        '{ROW_DROPPED, sh_p2c_pkg::CFG_MIN_RANGE, 17'd0,     12'd1,    16'd1000},
        '{ROW_WRITE,   sh_p2c_pkg::CFG_LEFT_SIDE, 17'd0,     12'd0,    16'd0},
        '{ROW_WRITE,   sh_p2c_pkg::CFG_SCAN_LEN,  17'd4096,  12'd0,    16'd0},
        '{ROW_WRITE,   sh_p2c_pkg::CFG_MIN_RANGE, 17'd1000,  12'd0,    16'd0},
        '{ROW_WRITE,   sh_p2c_pkg::CFG_MAX_RANGE, 17'd1200,  12'd0,    16'd0},
        '{ROW_DROPPED, sh_p2c_pkg::CFG_MIN_RANGE, 17'd0,     12'd10,   16'd1000},
        '{ROW_KEPT,    sh_p2c_pkg::CFG_MIN_RANGE, 17'd0,     12'd10,   16'd1001},
        '{ROW_KEPT,    sh_p2c_pkg::CFG_MIN_RANGE, 17'd0,     12'd10,   16'd1199},
        '{ROW_DROPPED, sh_p2c_pkg::CFG_MIN_RANGE, 17'd0,     12'd10,   16'd1200},
        '{ROW_WRITE,   sh_p2c_pkg::CFG_MAX_RANGE, 17'd0,     12'd0,    16'd0},
        '{ROW_DROPPED, sh_p2c_pkg::CFG_MIN_RANGE, 17'd0,     12'd10,   16'd500}
    };

    scan_half_polar_to_cartesian DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic bit project_sample(input logic [11:0] idx, input logic [15:0] rng,
                                          output t_cart_point pt);
        longint pos, reach, span, mid, upper, angle, x, y, z, dx, dy;
        bit     flip;
        pos   = longint'(idx);
        reach = longint'(rng);
        span  = (samples_per_scan > sh_p2c_pkg::MAX_SAMPLES)
                ? longint'(sh_p2c_pkg::MAX_SAMPLES) : longint'(samples_per_scan);
        mid   = span / 2;
        pt    = '0;
        if (use_left) begin
            if (!(pos > mid && pos < span))
                return 1'b0;
        end else if (!(pos < mid)) begin
            return 1'b0;
        end
        upper = (hi_limit_mm > sh_p2c_pkg::GATE_MM) ? longint'(sh_p2c_pkg::GATE_MM)
                                                    : longint'(hi_limit_mm);
        if (!(longint'(lo_gate_mm) < reach && reach < upper))
            return 1'b0;

        angle = longint'(angle_origin) + pos * longint'(angle_pitch);
        angle = (angle + HALF_TURN) % FULL_TURN;
        if (angle < 0)
            angle += FULL_TURN;
        angle -= HALF_TURN;
        flip = 1'b0;
        if (angle > QUARTER_TURN) begin
            angle -= HALF_TURN;
            flip = 1'b1;
        end else if (angle < -QUARTER_TURN) begin
            angle += HALF_TURN;
            flip = 1'b1;
        end
        z = angle * 4;
        x = (reach * RANGE_GAIN + 8192) >>> 14;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= arctan_q16[i];
            end else begin
                x += dx;
                y -= dy;
                z += arctan_q16[i];
            end
        end
        x = (x + 32768) >>> 16;
        y = (y + 32768) >>> 16;
        if (flip) begin
            x = -x;
            y = -y;
        end
        if (x > 2047) x = 2047;
        if (x < -2048) x = -2048;
        if (y > 2047) y = 2047;
        if (y < -2048) y = -2048;
        pt.x   = x[11:0];
        pt.y   = y[11:0];
        pt.idx = idx;
        return 1'b1;
    endfunction

    task automatic write_reg(input sh_p2c_pkg::t_cfg_index sel, input logic [16:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        unique case (sel)
            sh_p2c_pkg::CFG_MIN_RANGE: lo_gate_mm       = value[15:0];
            sh_p2c_pkg::CFG_MAX_RANGE: hi_limit_mm      = value[15:0];
            sh_p2c_pkg::CFG_START:     angle_origin     = value;
            sh_p2c_pkg::CFG_STEP:      angle_pitch      = value[12:0];
            sh_p2c_pkg::CFG_SCAN_LEN:  samples_per_scan = value[12:0];
            sh_p2c_pkg::CFG_LEFT_SIDE: use_left         = value[0];
            default: ;
        endcase
    endtask

    // drain the pipeline, then let dropped words clear out
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic send_sample(input logic [11:0] idx, input logic [15:0] rng,
                               input bit predicted);
        t_cart_point pt;
        while (!steady && $urandom_range(0, 99) < 14) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, rng, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        if (predicted && project_sample(idx, rng, pt))
            pending_points = {pending_points, pt};
        samples_sent++;
    endtask

    task automatic pick_setting();
        int pick;
        pick = $urandom_range(0, 99);
        write_reg(sh_p2c_pkg::CFG_MIN_RANGE, pick < 60 ? 17'd0 :
                  pick < 90 ? 17'($urandom_range(0, 300)) : 17'($urandom_range(0, 65535)));
        pick = $urandom_range(0, 99);
        write_reg(sh_p2c_pkg::CFG_MAX_RANGE, pick < 40 ? 17'd65535 :
                  pick < 80 ? 17'($urandom_range(800, 2000)) :
                  pick < 95 ? 17'($urandom_range(0, 65535)) : 17'd0);
        pick = $urandom_range(0, 99);
        write_reg(sh_p2c_pkg::CFG_START, pick < 10 ? 17'h136F0 :
                  pick < 20 ? 17'h0C910 : 17'($urandom_range(0, 131071)));
        pick = $urandom_range(0, 99);
        write_reg(sh_p2c_pkg::CFG_STEP, pick < 50 ? 17'($urandom_range(0, 4096)) :
                  pick < 80 ? 17'($urandom_range(0, 8191)) : 17'($urandom_range(0, 16)));
        pick = $urandom_range(0, 99);
        write_reg(sh_p2c_pkg::CFG_SCAN_LEN, pick < 15 ? 17'd4096 :
                  pick < 25 ? 17'($urandom_range(4097, 8191)) :
                  pick < 90 ? 17'($urandom_range(2, 4096)) : 17'($urandom_range(0, 3)));
        write_reg(sh_p2c_pkg::CFG_LEFT_SIDE, 17'($urandom_range(0, 1)));
        settings_used++;
    endtask

    task automatic send_random_sample();
        int          span, mid;
        logic [11:0] idx;
        logic [15:0] rng;
        span = (samples_per_scan > sh_p2c_pkg::MAX_SAMPLES) ? int'(sh_p2c_pkg::MAX_SAMPLES)
                                                            : int'(samples_per_scan);
        mid  = span / 2;
        if ($urandom_range(0, 99) < 85 && (use_left ? span - mid >= 2 : mid > 0)) begin
            idx = use_left ? 12'($urandom_range(mid + 1, span - 1))
                           : 12'($urandom_range(0, mid - 1));
        end else begin
            idx = 12'($urandom_range(0, 4095));
        end
        rng = ($urandom_range(0, 99) < 70) ? 16'($urandom_range(0, 1600))
                                           : 16'($urandom_range(0, 65535));
        send_sample(idx, rng, 1'b1);
    endtask

    initial begin : sink_ready
        int hold_left;
        hold_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_TICKS;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= steady || $urandom_range(0, 99) >= 14;
            end
        end
    end

    always @(posedge i_clk) begin : point_check
        t_cart_point seen, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen = m_axis_tdata[35:0];
            if (pending_points.size() == 0) begin
                if (fault_count < 10)
                    $display("unexpected point x=%0d y=%0d idx=%0d",
                             seen.x, seen.y, seen.idx);
                fault_count++;
            end else begin
                want = pending_points.pop_front();
                if (seen.x !== want.x || seen.y !== want.y || seen.idx !== want.idx) begin
                    if (fault_count < 10)
                        $display({"point mismatch: expected x=%0d y=%0d idx=%0d, ",
                                  "got x=%0d y=%0d idx=%0d"},
                                 want.x, want.y, want.idx, seen.x, seen.y, seen.idx);
                    fault_count++;
                end
                points_checked++;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || i_cfg_wr_en || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        lo_gate_mm       = 16'd0;
        hi_limit_mm      = 16'd65535;
        angle_origin     = 17'sd0;
        angle_pitch      = 13'd0;
        samples_per_scan = 13'd4096;
        use_left         = 1'b0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[n]) begin
            if (plan[n].kind == ROW_WRITE) begin
                settle();
                write_reg(plan[n].reg_sel, plan[n].reg_val);
            end else begin
                send_sample(plan[n].idx, plan[n].rng, plan[n].kind == ROW_KEPT);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            pick_setting();
            steady = (phase == 2);
            if (phase == 4)
                hold_req = 1'b1;
            repeat (PHASE_WORDS) send_random_sample();
        end
        steady = 1'b0;
        settle();

        $display("Sent %0d samples over %0d random register settings plus directed cases;",
                 samples_sent, settings_used);
        $display("checked %0d points, %0d mismatches", points_checked, fault_count);
        if (fault_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/sh_p2c_pkg.sv
hw/rtl/sh_p2c_prep.sv
hw/rtl/sh_p2c_cell.sv
hw/rtl/sh_p2c_post.sv
hw/rtl/scan_half_polar_to_cartesian.sv
bench/scan_half_polar_to_cartesian_test.sv
